FILE: rtl/mwm_pkg.sv
package mwm_pkg;

  // limb width and configuration register width
  localparam int LIMB_W = 32;
  localparam int CFG_W  = 6;

  // default operand size and register value after reset
  localparam int               MAX_WORDS_DEF = 32;
  localparam logic [CFG_W-1:0] WORDS_RESET   = 6'd32;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic issue;      // a step's memory reads go out this cycle
    logic first_row;  // partial product reads as zero on the first row
    logic carry_clr;  // start of a row
  } mac_ctl_t;

endpackage

FILE: rtl/mwm_ram.sv
module mwm_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mwm_mac.sv
module mwm_mac #(
  parameter int PA_W = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mwm_pkg::mac_ctl_t            ctl,
  input  logic [PA_W-1:0]              issue_addr,
  input  logic [mwm_pkg::LIMB_W-1:0]   a_q,
  input  logic [mwm_pkg::LIMB_W-1:0]   b_q,
  input  logic [mwm_pkg::LIMB_W-1:0]   p_q,
  output logic                         busy,
  output logic                         wr_en,
  output logic [PA_W-1:0]              wr_addr,
  output logic [mwm_pkg::LIMB_W-1:0]   wr_data,
  output logic [mwm_pkg::LIMB_W-1:0]   carry
);

  localparam int LW = mwm_pkg::LIMB_W;

  logic              v1_r, v2_r;
  logic              zero1_r;
  logic [PA_W-1:0]   addr1_r, addr2_r;
  logic [2*LW-1:0]   mul_r;
  logic [LW-1:0]     pd_r;
  logic [LW-1:0]     carry_r;
  logic [2*LW-1:0]   sum;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
    end
  end

  // stage 1: memory data back, one 32x32 multiply
  always_ff @(posedge clk) begin
    addr1_r <= issue_addr;
    zero1_r <= ctl.first_row;
    addr2_r <= addr1_r;
    mul_r   <= {{LW{1'b0}}, a_q} * {{LW{1'b0}}, b_q};
    pd_r    <= zero1_r ? '0 : p_q;
  end

  // stage 2: accumulate with the running carry
  assign sum = mul_r + {{LW{1'b0}}, pd_r} + {{LW{1'b0}}, carry_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else if (ctl.carry_clr) begin
      carry_r <= '0;
    end else if (v2_r) begin
      carry_r <= sum[2*LW-1:LW];
    end
  end

  assign busy    = v1_r | v2_r;
  assign wr_en   = v2_r;
  assign wr_addr = addr2_r;
  assign wr_data = sum[LW-1:0];
  assign carry   = carry_r;

endmodule

FILE: rtl/multiword_multiplier.sv
// Multiword unsigned multiplier, schoolbook method on 32-bit limbs.
// Input stream: each transfer carries one limb of each operand, least
// significant first (in_tdata[31:0] first operand, [63:32] second operand).
// cfg_we/cfg_wdata set the operand size N (0 acts as 1, above MAX_WORDS acts
// as MAX_WORDS) and restart the operand load; write it only when idle.
// After N input transfers the block computes the 2N-limb product and sends it
// on the output stream least significant limb first, tlast on the top limb.
// Each of the N rows consists of one second-operand read, N issued
// multiply-accumulate steps and a drain whose last cycle writes the carry;
// compute is bound by the single 32x32 multiply-accumulate unit and the one
// product memory port. Readout issues the next product memory read only once
// the previous one has reached the output register. Input is accepted only
// while the block is loading operands. A stalled receiver holds the output
// register and pauses the product readout. Reset sets the operand size
// register to 32, empties the load and drops any pending result; the
// memories need no clearing.
module multiword_multiplier #(
  parameter int MAX_WORDS = mwm_pkg::MAX_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [mwm_pkg::CFG_W-1:0]  cfg_wdata,   // operand_words
  // operand limbs
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,    // [31:0] a_word, [63:32] b_word
  // product limbs
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,   // [31:0] product_word
  output logic                       out_tlast    // last
);

  localparam int LW    = mwm_pkg::LIMB_W;
  localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int PA_W  = $clog2(2 * MAX_WORDS);
  localparam int KW    = PA_W + 1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_BREAD,
    S_ROW,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t                    state_r;
  logic [mwm_pkg::CFG_W-1:0] cfg_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [IDX_W-1:0]          ia_r, ib_r;
  logic [KW-1:0]             k_r;
  logic                      rd_pend_r, rd_last_r;
  logic                      out_tvalid_r, out_tlast_r;
  logic [LW-1:0]             out_tdata_r;

  logic [CNT_W-1:0]          n_w, n_m1;
  logic [KW-1:0]             tot_m1;
  logic                      in_xfer, row_issue, drain_done, out_issue;
  logic                      ia_last, ib_last, k_last;
  logic [PA_W-1:0]           row_addr;
  logic [LW-1:0]             a_q, b_q, p_q;
  logic                      p_we, p_re;
  logic [PA_W-1:0]           p_waddr, p_raddr;
  logic [LW-1:0]             p_wdata;
  mwm_pkg::mac_ctl_t         mac_ctl;
  logic                      mac_busy, mac_we;
  logic [PA_W-1:0]           mac_waddr;
  logic [LW-1:0]             mac_wdata, mac_carry;

  // effective operand size
  always_comb begin
    if (cfg_r == '0) begin
      n_w = CNT_W'(1);
    end else if (cfg_r > mwm_pkg::CFG_W'(MAX_WORDS)) begin
      n_w = CNT_W'(MAX_WORDS);
    end else begin
      n_w = CNT_W'(cfg_r);
    end
  end

  assign n_m1   = n_w - CNT_W'(1);
  assign tot_m1 = KW'({n_w, 1'b0}) - KW'(1);

  // handshakes and sequencing conditions
  assign in_tready  = (state_r == S_LOAD);
  assign in_xfer    = in_tvalid & in_tready;
  assign row_issue  = (state_r == S_ROW);
  assign drain_done = (state_r == S_DRAIN) && !mac_busy;
  assign out_issue  = (state_r == S_OUT) && !rd_pend_r && (!out_tvalid_r || out_tready);
  assign ia_last    = (CNT_W'(ia_r) == n_m1);
  assign ib_last    = (CNT_W'(ib_r) == n_m1);
  assign k_last     = (k_r == tot_m1);
  assign row_addr   = PA_W'(ia_r) + PA_W'(ib_r);

  // operand stores
  mwm_ram #(.DEPTH(MAX_WORDS), .AW(IDX_W), .DW(LW)) u_a_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_tdata[LW-1:0]),
    .re    (row_issue),
    .raddr (ia_r),
    .rdata (a_q)
  );

  mwm_ram #(.DEPTH(MAX_WORDS), .AW(IDX_W), .DW(LW)) u_b_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_tdata[2*LW-1:LW]),
    .re    (state_r == S_BREAD),
    .raddr (ib_r),
    .rdata (b_q)
  );

  // product store: mac writes, carry write at row end, readout
  assign p_we    = mac_we | drain_done;
  assign p_waddr = drain_done ? (PA_W'(ib_r) + PA_W'(n_w)) : mac_waddr;
  assign p_wdata = drain_done ? mac_carry : mac_wdata;
  assign p_re    = row_issue | out_issue;
  assign p_raddr = row_issue ? row_addr : k_r[PA_W-1:0];

  mwm_ram #(.DEPTH(2 * MAX_WORDS), .AW(PA_W), .DW(LW)) u_p_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_q)
  );

  // multiply-accumulate unit
  assign mac_ctl.issue     = row_issue;
  assign mac_ctl.first_row = (ib_r == '0);
  assign mac_ctl.carry_clr = (state_r == S_BREAD);

  mwm_mac #(.PA_W(PA_W)) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .issue_addr (row_addr),
    .a_q        (a_q),
    .b_q        (b_q),
    .p_q        (p_q),
    .busy       (mac_busy),
    .wr_en      (mac_we),
    .wr_addr    (mac_waddr),
    .wr_data    (mac_wdata),
    .carry      (mac_carry)
  );

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      cfg_r        <= mwm_pkg::WORDS_RESET;
      cnt_r        <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      k_r          <= '0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // product readout into the output register
      rd_pend_r <= out_issue;
      if (out_issue) begin
        rd_last_r <= k_last;
      end
      if (rd_pend_r) begin
        out_tdata_r  <= p_q;
        out_tlast_r  <= rd_last_r;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            if (cnt_r == n_m1) begin
              cnt_r   <= '0;
              ib_r    <= '0;
              state_r <= S_BREAD;
            end else begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        S_BREAD: begin
          ia_r    <= '0;
          state_r <= S_ROW;
        end
        S_ROW: begin
          if (ia_last) begin
            state_r <= S_DRAIN;
          end else begin
            ia_r <= ia_r + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (!mac_busy) begin
            if (ib_last) begin
              k_r     <= '0;
              state_r <= S_OUT;
            end else begin
              ib_r    <= ib_r + IDX_W'(1);
              state_r <= S_BREAD;
            end
          end
        end
        S_OUT: begin
          if (out_issue) begin
            k_r <= k_r + KW'(1);
            if (k_last) begin
              state_r <= S_LOAD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase

      // register write restarts the operand load
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
        cnt_r <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule
